### sv/temporal_weighted_neighbor_sampler_defines.svh
// Assertion macros for the temporal weighted neighbor sampler checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TEMPORAL_WEIGHTED_NEIGHBOR_SAMPLER_DEFINES_SVH
`define TEMPORAL_WEIGHTED_NEIGHBOR_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TWNS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TWNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/twns_pkg.sv
// Shared types, widths and codes for the temporal weighted neighbor sampler.
// No dependencies; used by every other file of the block but the RAM and the macro header.
package twns_pkg;

   // List depth
   localparam int MAX_NEIGHBORS = 64;

   // Field widths
   localparam int KIND_W  = 2;
   localparam int NODE_W  = 20;
   localparam int STAMP_W = 31;
   localparam int DRAW_W  = 37;

   // Index and count widths
   localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

   // Running weight sum, search target and entry widths
   localparam int CUM_W   = STAMP_W + IDX_W;
   localparam int TGT_W   = ((DRAW_W > CUM_W) ? DRAW_W : CUM_W) + 1;
   localparam int ENTRY_W = CUM_W + NODE_W + STAMP_W;

   // Request kinds
   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_APPEND = 2'd0;
   localparam kind_type KIND_CLEAR  = 2'd1;
   localparam kind_type KIND_QUERY  = 2'd2;

   // One stored list entry; cum is the inclusive running sum of stamps
   typedef struct packed {
      logic [CUM_W-1:0]   cum;
      logic [NODE_W-1:0]  node;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic append;
      logic clear;
      logic load_query;
      logic rd_mid1;
      logic step1;
      logic rd_start;
      logic set_target;
      logic rd_mid2;
      logic step2;
      logic rd_pick;
      logic load_hit;
      logic load_miss;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic search_open;
      logic start_ok;
      logic out_free;
   } dp_status_type;

endpackage

### sv/twns_if.sv
// Request and response channel interfaces (valid/ready handshake).
// Depends on twns_pkg for field widths.
interface twns_req_if;
   logic                              valid;
   logic                              ready;
   logic [twns_pkg::KIND_W-1:0]       kind;
   logic [twns_pkg::NODE_W-1:0]       node_id;
   logic [twns_pkg::STAMP_W-1:0]      stamp;
   logic [twns_pkg::DRAW_W-1:0]       random_draw;

   modport source  (output valid, kind, node_id, stamp, random_draw, input ready);
   modport sink    (input valid, kind, node_id, stamp, random_draw, output ready);
   modport monitor (input valid, ready, kind, node_id, stamp, random_draw);
endinterface

interface twns_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic [twns_pkg::NODE_W-1:0]       chosen_node;
   logic [twns_pkg::STAMP_W-1:0]      chosen_stamp;

   modport source  (output valid, found, chosen_node, chosen_stamp, input ready);
   modport sink    (input valid, found, chosen_node, chosen_stamp, output ready);
   modport monitor (input valid, ready, found, chosen_node, chosen_stamp);
endinterface

### sv/twns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/twns_datapath.sv
// Datapath: entry store, list count, search bounds, draw target, result register.
// Depends on twns_pkg and twns_ram.
module twns_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  twns_pkg::dp_cmd_type            cmd,
   output twns_pkg::dp_status_type         status,
   input  logic [twns_pkg::NODE_W-1:0]     req_node_id,
   input  logic [twns_pkg::STAMP_W-1:0]    req_stamp,
   input  logic [twns_pkg::DRAW_W-1:0]     req_random_draw,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_found,
   output logic [twns_pkg::NODE_W-1:0]     rsp_chosen_node,
   output logic [twns_pkg::STAMP_W-1:0]    rsp_chosen_stamp
);

   // List bookkeeping
   logic [twns_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [twns_pkg::CUM_W-1:0]   total_ff, total_in;
   logic                         full;

   // Query operands
   logic [twns_pkg::STAMP_W-1:0] qstamp_ff, qstamp_in;
   logic [twns_pkg::DRAW_W-1:0]  draw_ff, draw_in;
   logic [twns_pkg::TGT_W-1:0]   target_ff, target_in;

   // Search bounds: lo inclusive, hi exclusive
   logic [twns_pkg::CNT_W-1:0]   lo_ff, lo_in;
   logic [twns_pkg::CNT_W-1:0]   hi_ff, hi_in;
   logic [twns_pkg::IDX_W-1:0]   mid_ff, mid_in;
   logic [twns_pkg::IDX_W-1:0]   hit_ff, hit_in;
   logic                         hit_eq_ff, hit_eq_in;
   logic [twns_pkg::CNT_W-1:0]   mid1_wide, mid2_wide, start_idx, pick_wide, mid_plus1;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         found_ff, found_in;
   logic [twns_pkg::NODE_W-1:0]  node_ff, node_in;
   logic [twns_pkg::STAMP_W-1:0] ostamp_ff, ostamp_in;

   // Store port signals
   twns_pkg::entry_type          wr_entry, rd_entry;
   logic                         ram_wr_en, ram_rd_en;
   logic [twns_pkg::IDX_W-1:0]   ram_rd_addr;
   logic                         le_hit, eq_hit, ge_hit;

   twns_ram #(
      .WIDTH (twns_pkg::ENTRY_W),
      .DEPTH (twns_pkg::MAX_NEIGHBORS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[twns_pkg::IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_entry)
   );

   // Append path
   assign full      = (count_ff >= twns_pkg::CNT_W'(twns_pkg::MAX_NEIGHBORS));
   assign ram_wr_en = cmd.append && !full;
   always_comb begin
      wr_entry.cum   = total_ff + twns_pkg::CUM_W'(req_stamp);
      wr_entry.node  = req_node_id;
      wr_entry.stamp = req_stamp;
   end

   // Midpoints: first search uses lo + (hi-1-lo)/2, second lo + (hi-lo)/2
   assign mid1_wide = lo_ff + ((hi_ff - lo_ff - twns_pkg::CNT_W'(1)) >> 1);
   assign mid2_wide = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_plus1 = twns_pkg::CNT_W'(mid_ff) + twns_pkg::CNT_W'(1);
   assign start_idx = hit_eq_ff ? twns_pkg::CNT_W'(hit_ff) : lo_ff;
   // Draw past the total saturates to the last entry
   assign pick_wide = (lo_ff == count_ff) ? (count_ff - twns_pkg::CNT_W'(1)) : lo_ff;

   // Comparisons against the entry just read
   assign le_hit = (rd_entry.stamp <= qstamp_ff);
   assign eq_hit = (rd_entry.stamp == qstamp_ff);
   assign ge_hit = (twns_pkg::TGT_W'(rd_entry.cum) >= target_ff);

   // Read address select
   assign ram_rd_en = cmd.rd_mid1 || cmd.rd_mid2 || cmd.rd_start || cmd.rd_pick;
   always_comb begin
      ram_rd_addr = mid_ff;
      if (cmd.rd_mid1) begin
         ram_rd_addr = mid1_wide[twns_pkg::IDX_W-1:0];
      end else if (cmd.rd_mid2) begin
         ram_rd_addr = mid2_wide[twns_pkg::IDX_W-1:0];
      end else if (cmd.rd_start) begin
         ram_rd_addr = start_idx[twns_pkg::IDX_W-1:0];
      end else if (cmd.rd_pick) begin
         ram_rd_addr = pick_wide[twns_pkg::IDX_W-1:0];
      end
   end

   // Next-state logic for list and search registers
   always_comb begin
      count_in  = count_ff;
      total_in  = total_ff;
      qstamp_in = qstamp_ff;
      draw_in   = draw_ff;
      target_in = target_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      hit_in    = hit_ff;
      hit_eq_in = hit_eq_ff;

      if (ram_wr_en) begin
         count_in = count_ff + twns_pkg::CNT_W'(1);
         total_in = wr_entry.cum;
      end
      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
      end
      if (cmd.load_query) begin
         qstamp_in = req_stamp;
         draw_in   = req_random_draw;
         lo_in     = '0;
         hi_in     = count_ff;
         hit_eq_in = 1'b0;
      end
      if (cmd.rd_mid1) begin
         mid_in = mid1_wide[twns_pkg::IDX_W-1:0];
      end
      if (cmd.rd_mid2) begin
         mid_in = mid2_wide[twns_pkg::IDX_W-1:0];
      end
      // Start search: keep last entry at or before the query time
      if (cmd.step1) begin
         if (le_hit) begin
            hit_in    = mid_ff;
            hit_eq_in = eq_hit;
            lo_in     = mid_plus1;
         end else begin
            hi_in = twns_pkg::CNT_W'(mid_ff);
         end
      end
      if (cmd.rd_start) begin
         lo_in = start_idx;
         hi_in = count_ff;
      end
      // Target = draw + sum of weights before the start entry
      if (cmd.set_target) begin
         target_in = twns_pkg::TGT_W'(draw_ff) + twns_pkg::TGT_W'(rd_entry.cum)
                   - twns_pkg::TGT_W'(rd_entry.stamp);
      end
      // Pick search: first entry whose running sum reaches the target
      if (cmd.step2) begin
         if (ge_hit) begin
            hi_in = twns_pkg::CNT_W'(mid_ff);
         end else begin
            lo_in = mid_plus1;
         end
      end
   end

   // Result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      node_in      = node_ff;
      ostamp_in    = ostamp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_hit) begin
         rsp_valid_in = 1'b1;
         found_in     = 1'b1;
         node_in      = rd_entry.node;
         ostamp_in    = rd_entry.stamp;
      end else if (cmd.load_miss) begin
         rsp_valid_in = 1'b1;
         found_in     = 1'b0;
         node_in      = '0;
         ostamp_in    = '0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qstamp_ff <= qstamp_in;
      draw_ff   <= draw_in;
      target_ff <= target_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      hit_ff    <= hit_in;
      hit_eq_ff <= hit_eq_in;
      found_ff  <= found_in;
      node_ff   <= node_in;
      ostamp_ff <= ostamp_in;
   end

   // Status and outputs
   assign status.search_open = (lo_ff < hi_ff);
   assign status.start_ok    = (start_idx < count_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_chosen_node  = node_ff;
   assign rsp_chosen_stamp = ostamp_ff;

endmodule

### sv/twns_ctrl.sv
// Controller: sequences the start search, target setup, pick search and result load.
// Depends on twns_pkg.
module twns_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [twns_pkg::KIND_W-1:0]   req_kind,
   output logic                          req_ready,
   input  twns_pkg::dp_status_type       status,
   output twns_pkg::dp_cmd_type          cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S1_CHECK,
      ST_S1_CMP,
      ST_S1_DONE,
      ST_S2_BASE,
      ST_S2_CHECK,
      ST_S2_CMP,
      ST_OUT_HIT,
      ST_OUT_MISS
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  twns_pkg::KIND_APPEND: cmd.append = 1'b1;
                  twns_pkg::KIND_CLEAR:  cmd.clear  = 1'b1;
                  twns_pkg::KIND_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in       = ST_S1_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_S1_CHECK: begin
            if (status.search_open) begin
               cmd.rd_mid1 = 1'b1;
               state_in    = ST_S1_CMP;
            end else begin
               state_in = ST_S1_DONE;
            end
         end
         ST_S1_CMP: begin
            cmd.step1 = 1'b1;
            state_in  = ST_S1_CHECK;
         end
         ST_S1_DONE: begin
            if (status.start_ok) begin
               cmd.rd_start = 1'b1;
               state_in     = ST_S2_BASE;
            end else begin
               state_in = ST_OUT_MISS;
            end
         end
         ST_S2_BASE: begin
            cmd.set_target = 1'b1;
            state_in       = ST_S2_CHECK;
         end
         ST_S2_CHECK: begin
            if (status.search_open) begin
               cmd.rd_mid2 = 1'b1;
               state_in    = ST_S2_CMP;
            end else begin
               cmd.rd_pick = 1'b1;
               state_in    = ST_OUT_HIT;
            end
         end
         ST_S2_CMP: begin
            cmd.step2 = 1'b1;
            state_in  = ST_S2_CHECK;
         end
         ST_OUT_HIT: begin
            if (status.out_free) begin
               cmd.load_hit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT_MISS: begin
            if (status.out_free) begin
               cmd.load_miss = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/temporal_weighted_neighbor_sampler.sv
// Temporal weighted neighbor sampler: append, clear and sampled query over a neighbor list.
// Append and clear are carried out on acceptance. A query runs a start search of S1
// binary-search steps, then target setup and a pick search of S2 steps (at most 7 each);
// a miss ends after the start search. One query at a time: the next transaction is taken
// in the cycle after result load; both searches share the entry store's single read port.
// Synchronous active-high reset empties the list and drops a pending response.
module temporal_weighted_neighbor_sampler (
   input  logic       clock,
   input  logic       reset,
   twns_req_if.sink   req_chan,
   twns_rsp_if.source rsp_chan
);

   twns_pkg::dp_cmd_type    cmd;
   twns_pkg::dp_status_type status;
   logic                    ready;

   twns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   twns_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_id      (req_chan.node_id),
      .req_stamp        (req_chan.stamp),
      .req_random_draw  (req_chan.random_draw),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_found        (rsp_chan.found),
      .rsp_chosen_node  (rsp_chan.chosen_node),
      .rsp_chosen_stamp (rsp_chan.chosen_stamp)
   );

   assign req_chan.ready = ready;

endmodule

### sv/twns_checker.sv
// Port-level checker for the temporal weighted neighbor sampler, bound to the top level.
// Depends on twns_pkg and the assertion macro header.
`include "temporal_weighted_neighbor_sampler_defines.svh"

module twns_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [twns_pkg::KIND_W-1:0]  req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_found,
   input logic [twns_pkg::NODE_W-1:0]  rsp_chosen_node,
   input logic [twns_pkg::STAMP_W-1:0] rsp_chosen_stamp
);

   logic req_fire, req_query, rsp_stall, rsp_miss_zero;
   logic [twns_pkg::NODE_W+twns_pkg::STAMP_W:0] rsp_payload;

   assign req_fire      = req_valid && req_ready;
   assign req_query     = (req_kind == twns_pkg::KIND_QUERY);
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_payload   = {rsp_found, rsp_chosen_node, rsp_chosen_stamp};
   assign rsp_miss_zero = (rsp_chosen_node == '0) && (rsp_chosen_stamp == '0);

   // Stalled response holds valid and payload
   `TWNS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // A not-found response carries zero node and stamp
   `TWNS_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_miss_zero, "nonzero miss payload")

   // Append, clear or unknown kinds never raise a response
   `TWNS_ASSERT_NEXT(a_no_spurious, clock, reset, req_fire && !req_query && !rsp_valid, !rsp_valid, "response without a query")

   // A query occupies the block for at least the next cycle
   `TWNS_ASSERT_NEXT(a_query_busy, clock, reset, req_fire && req_query, !req_ready, "request taken during a query")

endmodule

bind temporal_weighted_neighbor_sampler twns_checker u_twns_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_kind         (req_chan.kind),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_found        (rsp_chan.found),
   .rsp_chosen_node  (rsp_chan.chosen_node),
   .rsp_chosen_stamp (rsp_chan.chosen_stamp)
);

### tb/tb_temporal_weighted_neighbor_sampler.sv
// Testbench for temporal_weighted_neighbor_sampler: directed and random append, clear and
// sample transactions, each result checked against a neighbor-list predictor kept in the bench.
// Depends on twns_pkg, twns_if and the sampler RTL.
module tb_temporal_weighted_neighbor_sampler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam twns_pkg::kind_type           KIND_UNUSED  = 2'd3;
   localparam logic [twns_pkg::STAMP_W-1:0] STAMP_MAX    = '1;
   localparam logic [twns_pkg::DRAW_W-1:0]  DRAW_MAX     = '1;
   localparam int                           ITEM_TARGET  = 650;
   localparam int                           PHASE_LEN    = 90;
   localparam int                           DRAIN_CYCLES = 150;

   typedef struct packed {
      twns_pkg::kind_type           kind;
      logic [twns_pkg::NODE_W-1:0]  node;
      logic [twns_pkg::STAMP_W-1:0] stamp;
      logic [twns_pkg::DRAW_W-1:0]  draw;
   } nbr_req_type;

   typedef struct packed {
      logic                         found;
      logic [twns_pkg::NODE_W-1:0]  node;
      logic [twns_pkg::STAMP_W-1:0] stamp;
   } nbr_pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Bench-side drive registers
   logic                         drv_valid     = 1'b0;
   twns_pkg::kind_type           drv_kind      = twns_pkg::KIND_APPEND;
   logic [twns_pkg::NODE_W-1:0]  drv_node      = '0;
   logic [twns_pkg::STAMP_W-1:0] drv_stamp     = '0;
   logic [twns_pkg::DRAW_W-1:0]  drv_draw      = '0;
   logic                         drv_rsp_ready = 1'b0;

   twns_req_if req_if ();
   twns_rsp_if rsp_if ();

   assign req_if.valid       = drv_valid;
   assign req_if.kind        = drv_kind;
   assign req_if.node_id     = drv_node;
   assign req_if.stamp       = drv_stamp;
   assign req_if.random_draw = drv_draw;
   assign rsp_if.ready       = drv_rsp_ready;

   temporal_weighted_neighbor_sampler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Bench copy of the neighbor list
   logic [twns_pkg::NODE_W-1:0]  list_node  [twns_pkg::MAX_NEIGHBORS];
   logic [twns_pkg::STAMP_W-1:0] list_stamp [twns_pkg::MAX_NEIGHBORS];
   int                           list_len = 0;

   nbr_req_type  req_backlog [$];
   nbr_pick_type pending_picks [$];
   logic [twns_pkg::STAMP_W-1:0] gen_stamps [$];   // list as the generator expects it
   int  item_total  = 0;
   int  taken_count = 0;
   int  faults      = 0;
   logic req_taken  = 1'b0;

   // Clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Reset: asserted at start, released on a falling edge
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Run limit
   initial begin
      #3ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Idling phases rotate with the number of accepted transactions
   function automatic int send_idle_pct();
      case ((taken_count / PHASE_LEN) % 4)
         1: return 57;
         3: return 35;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct();
      case ((taken_count / PHASE_LEN) % 4)
         2: return 57;
         3: return 35;
         default: return 0;
      endcase
   endfunction

   // Predictor: updates the list and returns the sample result of a query
   function automatic void predict_sample(input nbr_req_type r, output bit has_pick,
                                          output nbr_pick_type pick);
      int lo, hi, hit, mid, start, sel, i;
      logic [63:0] run;
      bit done;
      has_pick = 1'b0;
      pick     = '0;
      case (r.kind)
         twns_pkg::KIND_APPEND: begin
            // a full list drops the entry
            if (list_len < twns_pkg::MAX_NEIGHBORS) begin
               list_node[list_len]  = r.node;
               list_stamp[list_len] = r.stamp;
               list_len++;
            end
         end
         twns_pkg::KIND_CLEAR: list_len = 0;
         twns_pkg::KIND_QUERY: begin
            has_pick = 1'b1;
            // binary search: last entry at the query time, else first later one
            lo  = 0;
            hi  = list_len - 1;
            hit = -1;
            while (lo <= hi) begin
               mid = lo + (hi - lo) / 2;
               if (list_stamp[mid] <= r.stamp) begin
                  hit = mid;
                  lo  = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
            start = (hit >= 0 && list_stamp[hit] == r.stamp) ? hit : lo;
            if (start < list_len) begin
               // first entry whose running sum reaches the draw, else the last one
               sel  = list_len - 1;
               run  = '0;
               done = 1'b0;
               for (i = start; i < list_len && !done; i++) begin
                  run = run + 64'(list_stamp[i]);
                  if (64'(r.draw) <= run) begin
                     sel  = i;
                     done = 1'b1;
                  end
               end
               pick.found = 1'b1;
               pick.node  = list_node[sel];
               pick.stamp = list_stamp[sel];
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [twns_pkg::DRAW_W-1:0] rand_draw();
      logic [twns_pkg::DRAW_W-1:0] d;
      d = twns_pkg::DRAW_W'({$urandom, $urandom});
      return d;
   endfunction

   // Queue one transaction and track the list it should build
   task automatic push_item(input twns_pkg::kind_type k,
                            input logic [twns_pkg::NODE_W-1:0] n,
                            input logic [twns_pkg::STAMP_W-1:0] s,
                            input logic [twns_pkg::DRAW_W-1:0] d);
      nbr_req_type r;
      r.kind  = k;
      r.node  = n;
      r.stamp = s;
      r.draw  = d;
      req_backlog = {req_backlog, r};
      if (k != KIND_UNUSED)
         item_total++;
      if (k == twns_pkg::KIND_APPEND && gen_stamps.size() < twns_pkg::MAX_NEIGHBORS)
         gen_stamps = {gen_stamps, s};
      else if (k == twns_pkg::KIND_CLEAR)
         gen_stamps.delete();
   endtask

   // Query aimed at stored times and at running-sum boundaries
   task automatic push_query_near();
      int n, k, start, j;
      logic [twns_pkg::STAMP_W-1:0] t;
      logic [63:0] total, part, d;
      n = gen_stamps.size();
      k = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
      case ($urandom_range(0, 5))
         0, 1:    t = (n > 0) ? gen_stamps[k] : twns_pkg::STAMP_W'($urandom);
         2:       t = (n > 0) ? gen_stamps[k] - twns_pkg::STAMP_W'(1) : '0;
         3:       t = (n > 0) ? gen_stamps[k] + twns_pkg::STAMP_W'(1) : STAMP_MAX;
         4:       t = $urandom_range(0, 1) ? STAMP_MAX : '0;
         default: t = twns_pkg::STAMP_W'($urandom);
      endcase
      start = n;
      for (j = n - 1; j >= 0; j--)
         if (gen_stamps[j] >= t)
            start = j;
      total = '0;
      part  = '0;
      k     = (start < n) ? int'($urandom_range(start, n - 1)) : n;
      for (j = start; j < n; j++) begin
         total = total + 64'(gen_stamps[j]);
         if (j <= k)
            part = total;
      end
      case ($urandom_range(0, 7))
         0:       d = '0;
         1:       d = part;
         2:       d = (part > 0) ? part - 64'd1 : '0;
         3:       d = part + 64'd1;
         4:       d = total;
         5:       d = total + 64'($urandom_range(1, 1000));
         6:       d = {$urandom, $urandom} % (total + 64'd1);
         default: d = 64'(DRAW_MAX);
      endcase
      if (d > 64'(DRAW_MAX))
         d = 64'(DRAW_MAX);
      push_item(twns_pkg::KIND_QUERY, twns_pkg::NODE_W'($urandom), t,
                d[twns_pkg::DRAW_W-1:0]);
   endtask

   // Any kind, any payload: unknown kinds, unordered appends, wild queries
   task automatic push_noise();
      push_item(twns_pkg::kind_type'($urandom_range(0, 3)), twns_pkg::NODE_W'($urandom),
                twns_pkg::STAMP_W'($urandom), rand_draw());
   endtask

   // One clear, a list of appends, then queries against it
   task automatic push_episode();
      int n, style, j, nq;
      int unsigned step_max;
      logic [63:0] cur;
      push_item(twns_pkg::KIND_CLEAR, twns_pkg::NODE_W'($urandom),
                twns_pkg::STAMP_W'($urandom), rand_draw());
      if ($urandom_range(0, 9) == 0)
         n = int'($urandom_range(twns_pkg::MAX_NEIGHBORS - 2, twns_pkg::MAX_NEIGHBORS + 4));
      else
         n = int'($urandom_range(1, 12));
      style = int'($urandom_range(0, 6));
      case (style)
         0, 1: begin
            cur      = 64'($urandom_range(0, 20));
            step_max = 3;
         end
         2, 3: begin
            cur      = 64'($urandom_range(0, 32'h7FFF_FFFF));
            step_max = 65535;
         end
         default: begin
            cur      = '0;
            step_max = 32'h0200_0000;
         end
      endcase
      for (j = 0; j < n; j++) begin
         if (style == 6) begin
            cur = 64'($urandom_range(0, 32'h7FFF_FFFF));
         end else if (j > 0) begin
            cur = cur + 64'($urandom_range(0, step_max));
            if (cur > 64'(STAMP_MAX))
               cur = 64'(STAMP_MAX);
         end
         push_item(twns_pkg::KIND_APPEND, twns_pkg::NODE_W'($urandom),
                   cur[twns_pkg::STAMP_W-1:0], rand_draw());
      end
      nq = int'($urandom_range(2, 8));
      for (j = 0; j < nq; j++) begin
         if ($urandom_range(0, 9) == 0)
            push_noise();
         push_query_near();
      end
   endtask

   // Stimulus and end of run
   initial begin
      // empty list, unknown kind
      push_item(twns_pkg::KIND_QUERY, '0, '0, '0);
      push_item(KIND_UNUSED, '1, STAMP_MAX, DRAW_MAX);
      // zero-weight entries, duplicate times, field extremes
      push_item(twns_pkg::KIND_APPEND, '0, '0, DRAW_MAX);
      push_item(twns_pkg::KIND_APPEND, '1, '0, '0);
      push_item(twns_pkg::KIND_APPEND, 20'h12345, 31'd5, '0);
      push_item(twns_pkg::KIND_APPEND, 20'h00777, 31'd5, '0);
      push_item(twns_pkg::KIND_APPEND, 20'hABCDE, STAMP_MAX, '0);
      push_item(twns_pkg::KIND_QUERY, '0, '0, '0);          // zero weight reaches the draw
      push_item(twns_pkg::KIND_QUERY, '1, '0, 37'd5);
      push_item(twns_pkg::KIND_QUERY, '0, 31'd5, 37'd6);    // last match of a repeated time
      push_item(twns_pkg::KIND_QUERY, '0, 31'd3, '0);       // first later entry
      push_item(twns_pkg::KIND_QUERY, '0, STAMP_MAX, DRAW_MAX);  // draw above total saturates
      push_item(twns_pkg::KIND_QUERY, '0, 31'd6, DRAW_MAX);
      push_item(twns_pkg::KIND_QUERY, '0, STAMP_MAX, twns_pkg::DRAW_W'(STAMP_MAX));
      // clear, then nothing eligible
      push_item(twns_pkg::KIND_CLEAR, '1, STAMP_MAX, DRAW_MAX);
      push_item(twns_pkg::KIND_QUERY, '0, 31'd9, 37'd1);
      // appends out of time order
      push_item(twns_pkg::KIND_APPEND, 20'd11, 31'd50, '0);
      push_item(twns_pkg::KIND_APPEND, 20'd22, 31'd10, '0);
      push_item(twns_pkg::KIND_APPEND, 20'd33, 31'd30, '0);
      push_item(twns_pkg::KIND_QUERY, '0, 31'd30, '0);
      push_item(twns_pkg::KIND_QUERY, '0, 31'd10, 37'd100);
      push_item(twns_pkg::KIND_QUERY, '0, 31'd51, 37'd1);
      push_item(KIND_UNUSED, '0, '0, '0);
      push_item(twns_pkg::KIND_QUERY, '0, '0, 37'd1);

      while (item_total < ITEM_TARGET)
         push_episode();

      // drain: everything accepted and every result back
      @(negedge clock iff !reset);
      while (req_backlog.size() != 0 || drv_valid || pending_picks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Request driver: next transaction or an idle cycle, on the falling edge
   always @(negedge clock) begin : drive_req
      nbr_req_type nxt;
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_taken) begin
         if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
            nxt = req_backlog.pop_front();
            drv_valid <= 1'b1;
            drv_kind  <= nxt.kind;
            drv_node  <= nxt.node;
            drv_stamp <= nxt.stamp;
            drv_draw  <= nxt.draw;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      drv_rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct());
   end

   // Monitor: check results, then predict from accepted requests
   always @(posedge clock) begin : watch
      nbr_req_type  acc;
      nbr_pick_type want;
      nbr_pick_type pick;
      bit           has_pick;
      req_taken <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_picks.size() == 0) begin
               $error("unexpected result: found %0d node %0d stamp %0d",
                      rsp_if.found, rsp_if.chosen_node, rsp_if.chosen_stamp);
               faults++;
            end else begin
               want = pending_picks.pop_front();
               if (rsp_if.found !== want.found) begin
                  $error("found mismatch: expected %0d, got %0d", want.found, rsp_if.found);
                  faults++;
               end
               if (rsp_if.chosen_node !== want.node) begin
                  $error("chosen_node mismatch: expected %0d, got %0d",
                         want.node, rsp_if.chosen_node);
                  faults++;
               end
               if (rsp_if.chosen_stamp !== want.stamp) begin
                  $error("chosen_stamp mismatch: expected %0d, got %0d",
                         want.stamp, rsp_if.chosen_stamp);
                  faults++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            acc.kind  = req_if.kind;
            acc.node  = req_if.node_id;
            acc.stamp = req_if.stamp;
            acc.draw  = req_if.random_draw;
            predict_sample(acc, has_pick, pick);
            if (has_pick)
               pending_picks = {pending_picks, pick};
            taken_count++;
         end
      end
   end

endmodule
